// ===== rtl/rotated_pattern_match_macros.svh =====
`ifndef ROTATED_PATTERN_MATCH_MACROS_SVH
`define ROTATED_PATTERN_MATCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rotated_pattern_match: assertion failed");

// Next-cycle implication, checked outside reset.
`define RPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rotated_pattern_match: assertion failed");

`endif

// ===== rtl/rpm_pkg.sv =====
package rpm_pkg;

	localparam int CMD_W       = 2;
	localparam int INDEX_W     = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 32;
	localparam int ROT_W       = 3;
	localparam int LEN_W       = 4;
	localparam int MAX_RESULTS = 8;

	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	typedef logic [POS_W-1:0] pos_t;

	// Second stage status handed to the result emitter.
	typedef struct packed {
		logic valid;
		pos_t position;
	} s2_ctl_t;

endpackage

// ===== rtl/rpm_front.sv =====
module rpm_front #(
	parameter int MAX_PAT    = 8,
	parameter int DATA_WIDTH = 32,
	parameter int LW         = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rpm_pkg::CMD_W-1:0]           cmd,
	input  logic [rpm_pkg::INDEX_W-1:0]         index,
	input  logic signed [rpm_pkg::VALUE_W-1:0]  value,
	input  logic                                cfg_we,
	input  logic [rpm_pkg::LEN_W-1:0]           cfg_wdata,
	input  logic                                emit_free,
	output rpm_pkg::s2_ctl_t                    s2_ctl,
	output logic [LW-1:0]                       len_s2,
	output logic [MAX_PAT-1:0][MAX_PAT-1:0]     eq_s2
);

	localparam int SW = (DATA_WIDTH < rpm_pkg::VALUE_W) ? DATA_WIDTH : rpm_pkg::VALUE_W;

	logic                          valid_s1;
	logic [rpm_pkg::CMD_W-1:0]     cmd_s1;
	logic [rpm_pkg::INDEX_W-1:0]   index_s1;
	logic [SW-1:0]                 value_s1;

	logic [rpm_pkg::LEN_W-1:0]     length_q;
	rpm_pkg::pos_t                 count_q;
	logic [SW-1:0]                 pattern_q [MAX_PAT];
	logic [SW-1:0]                 window_q  [MAX_PAT];

	logic                          valid_s2;
	rpm_pkg::pos_t                 pos_s2;

	logic                          s2_free;
	logic                          s1_adv;
	logic                          is_sample;
	logic [LW-1:0]                 len_eff;
	rpm_pkg::pos_t                 count_inc;
	logic                          at_len;
	logic [SW-1:0]                 window_next [MAX_PAT];
	logic [MAX_PAT-1:0][MAX_PAT-1:0] eq_next;

	assign s2_free   = !valid_s2 || emit_free;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign is_sample = (cmd_s1 == rpm_pkg::CMD_SAMPLE);
	assign s2_ctl    = '{valid: valid_s2, position: pos_s2};

	// Out-of-range lengths are clamped into 1..MAX_PAT.
	always_comb begin
		if (length_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(length_q) > MAX_PAT) begin
			len_eff = LW'(MAX_PAT);
		end else begin
			len_eff = LW'(length_q);
		end
	end

	assign count_inc = (&count_q) ? count_q : count_q + rpm_pkg::POS_W'(1);
	assign at_len    = (count_inc >= rpm_pkg::POS_W'(len_eff));

	always_comb begin
		window_next[0] = value_s1;
		for (int i = 1; i < MAX_PAT; i++) begin
			window_next[i] = window_q[i-1];
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_PAT; k++) begin
			for (int p = 0; p < MAX_PAT; p++) begin
				eq_next[k][p] = (window_next[k] == pattern_q[p]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			count_q  <= '0;
			length_q <= rpm_pkg::LEN_W'(1);
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_adv && is_sample && at_len;
			end
			if (s1_adv) begin
				unique case (cmd_s1)
					rpm_pkg::CMD_SAMPLE:  count_q <= count_inc;
					rpm_pkg::CMD_RESTART: count_q <= '0;
					default:              count_q <= count_q;
				endcase
			end
			if (cfg_we) begin
				length_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			cmd_s1   <= cmd;
			index_s1 <= index;
			value_s1 <= value[SW-1:0];
		end
		if (s1_adv && (cmd_s1 == rpm_pkg::CMD_WRITE)) begin
			for (int p = 0; p < MAX_PAT; p++) begin
				if (32'(index_s1) == p) begin
					pattern_q[p] <= value_s1;
				end
			end
		end
		if (s1_adv && is_sample) begin
			window_q <= window_next;
		end
		if (s2_free) begin
			pos_s2 <= count_inc - rpm_pkg::POS_W'(len_eff);
			len_s2 <= len_eff;
			eq_s2  <= eq_next;
		end
	end

endmodule

// ===== rtl/rpm_emit.sv =====
module rpm_emit #(
	parameter int MAX_PAT = 8,
	parameter int LW      = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rpm_pkg::s2_ctl_t                s2_ctl,
	input  logic [LW-1:0]                   len_s2,
	input  logic [MAX_PAT-1:0][MAX_PAT-1:0] eq_s2,
	output logic                            emit_free,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rpm_pkg::POS_W-1:0]       position,
	output logic [rpm_pkg::ROT_W-1:0]       rotation,
	output logic                            last
);

	localparam int AW     = $clog2(MAX_PAT);
	localparam int SENT_W = $clog2(rpm_pkg::MAX_RESULTS);

	logic                 busy_q;
	logic [SENT_W-1:0]    sent_q;
	logic [MAX_PAT-1:0]   vec_q;
	rpm_pkg::pos_t        pos_q;

	logic [MAX_PAT-1:0]   match;
	logic [MAX_PAT-1:0]   vec_rest;
	logic [AW-1:0]        low_idx;
	logic                 out_take;
	logic                 load;

	// Rotation r needs window word k (k = 0 newest) to equal pattern word
	// (r + len - 1 - k) mod len for every k below the length.
	always_comb begin
		int idx;
		int len_i;
		len_i = int'(len_s2);
		match = '0;
		for (int r = 0; r < MAX_PAT; r++) begin
			match[r] = (r < len_i);
			for (int k = 0; k < MAX_PAT; k++) begin
				idx = r + len_i - 1 - k;
				if (idx >= len_i) begin
					idx = idx - len_i;
				end
				if (k < len_i && r < len_i) begin
					match[r] = match[r] & eq_s2[k][idx[AW-1:0]];
				end
			end
		end
	end

	always_comb begin
		low_idx = '0;
		for (int i = MAX_PAT - 1; i >= 0; i--) begin
			if (vec_q[i]) begin
				low_idx = AW'(i);
			end
		end
	end

	assign vec_rest  = vec_q & (vec_q - MAX_PAT'(1));
	assign last      = (sent_q == SENT_W'(rpm_pkg::MAX_RESULTS - 1)) || (vec_rest == '0);
	assign out_valid = busy_q;
	assign out_take  = busy_q && !out_stall;
	assign emit_free = !busy_q || (out_take && last);
	assign load      = s2_ctl.valid && emit_free;
	assign position  = pos_q;
	assign rotation  = rpm_pkg::ROT_W'(low_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sent_q <= '0;
		end else if (load) begin
			busy_q <= |match;
			sent_q <= '0;
		end else if (out_take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				sent_q <= sent_q + SENT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vec_q <= match;
			pos_q <= s2_ctl.position;
		end else if (out_take && !last) begin
			vec_q <= vec_rest;
		end
	end

endmodule

// ===== rtl/rotated_pattern_match.sv =====
// An accepted sample passes the first stage, second stage and emitter registers before its first result shows.
// Throughput: one transaction per cycle; a sample with n matches gives n results
// (at most eight) from the single result emitter, and the input stalls once both stage
// registers in front of the emitter are full and the emitter cannot take the second stage.
// Reset clears the pipeline valids, the sample count and the emitter, and sets the
// pattern length to 1; the pattern table and sample window hold no value until written.
module rotated_pattern_match #(
	parameter int MAX_PAT    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rpm_pkg::CMD_W-1:0]           cmd,
	input  logic [rpm_pkg::INDEX_W-1:0]         index,
	input  logic signed [rpm_pkg::VALUE_W-1:0]  value,
	input  logic                                cfg_we,
	input  logic [rpm_pkg::LEN_W-1:0]           cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rpm_pkg::POS_W-1:0]           position,
	output logic [rpm_pkg::ROT_W-1:0]           rotation,
	output logic                                last
);

	localparam int LW = $clog2(MAX_PAT + 1);

	rpm_pkg::s2_ctl_t                s2_ctl;
	logic [LW-1:0]                   len_s2;
	logic [MAX_PAT-1:0][MAX_PAT-1:0] eq_s2;
	logic                            emit_free;

	rpm_front #(
		.MAX_PAT    (MAX_PAT),
		.DATA_WIDTH (DATA_WIDTH),
		.LW         (LW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.index     (index),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.emit_free (emit_free),
		.s2_ctl    (s2_ctl),
		.len_s2    (len_s2),
		.eq_s2     (eq_s2)
	);

	rpm_emit #(
		.MAX_PAT (MAX_PAT),
		.LW      (LW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_ctl    (s2_ctl),
		.len_s2    (len_s2),
		.eq_s2     (eq_s2),
		.emit_free (emit_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.position  (position),
		.rotation  (rotation),
		.last      (last)
	);

endmodule

// ===== rtl/rpm_checker.sv =====
`include "rotated_pattern_match_macros.svh"

module rpm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rpm_pkg::POS_W-1:0]     position,
	input logic [rpm_pkg::ROT_W-1:0]     rotation,
	input logic                          last
);

	// A stalled result transaction keeps its payload.
	`RPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(position) && $stable(rotation) && $stable(last))

	// Results of one sample follow each other without a gap and share a position.
	`RPM_ASSERT_NEXT(a_burst_cont, clk, arst_n, out_valid && !out_stall && !last, out_valid && (position == $past(position)))

	// Input only backs up behind a pending result.
	`RPM_ASSERT_IMP(a_stall_cause, clk, arst_n, !out_valid, !in_stall)

endmodule

bind rotated_pattern_match rpm_checker u_rpm_checker (.*);
